>>> rtl/core/hrhp_pkg.sv
`timescale 1ns / 1ps
package hrhp_pkg;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_TARGET  = 3'd1,
      PH_VERSION = 3'd2,
      PH_HEADERS = 3'd3,
      PH_BODY    = 3'd4,
      PH_DONE    = 3'd5
   } parse_phase_type;

   typedef enum logic [2:0] {
      LP_LEAD  = 3'd0,
      LP_NAME  = 3'd1,
      LP_SEEK  = 3'd2,
      LP_GAP   = 3'd3,
      LP_VALUE = 3'd4
   } line_phase_type;

   localparam logic [2:0] TK_METHOD  = 3'd0;
   localparam logic [2:0] TK_TARGET  = 3'd1;
   localparam logic [2:0] TK_VERSION = 3'd2;
   localparam logic [2:0] TK_NAME    = 3'd3;
   localparam logic [2:0] TK_VALUE   = 3'd4;
   localparam logic [2:0] TK_HEND    = 3'd5;
   localparam logic [2:0] TK_BODY    = 3'd6;
   localparam logic [2:0] TK_DONE    = 3'd7;

   localparam logic [3:0] NAME_LEN   = 4'd14;
   localparam logic [3:0] NUM_STOP   = 4'd15;
   localparam logic [31:0] LEN_SAT   = 32'h7FFF_FFFF;
   localparam logic [31:0] NO_LENGTH = 32'hFFFF_FFFF;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // One token event as it travels from the parser through the queue.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] offset;
      logic [31:0] length;
      logic [31:0] body_len;
      logic        last;
   } event_type;

   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/http_request_head_parser.sv
`timescale 1ns / 1ps
// A token event is registered into the event queue as the byte that ends it is taken.
// Throughput: one request byte per cycle, while the four-entry event queue has room for two.
// A byte can emit two events; the rsp_ side drains one event per cycle while rsp_ready is high.
// Reset (synchronous, active high) returns the parser to the method phase with offset zero,
// no declared length, and an empty event queue.
module http_request_head_parser import hrhp_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_token_kind,
   output logic [31:0]        rsp_token_offset,
   output logic [31:0]        rsp_token_length,
   output logic signed [31:0] rsp_body_length,
   output logic               rsp_last_of_run
);

   // The front parser classifies each byte and produces up to two events,
   // which the queue holds until the rsp_ side takes each transfer.
   logic      ev_push, ev_two, room2;
   event_type ev0, ev1, head;

   hrhp_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .byte_valid(req_valid), .byte_data(req_data_byte), .byte_ready(req_ready),
      .ev_push(ev_push), .ev_two(ev_two), .ev0(ev0), .ev1(ev1), .q_room2(room2)
   );

   hrhp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(ev_push), .push_two(ev_two), .din0(ev0), .din1(ev1),
      .room2(room2), .out_valid(rsp_valid), .dout(head), .out_ready(rsp_ready)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_offset = head.offset;
   assign rsp_token_length = head.length;
   assign rsp_body_length  = head.body_len;
   assign rsp_last_of_run  = head.last;

endmodule

>>> rtl/core/hrhp_front.sv
`timescale 1ns / 1ps
module hrhp_front import hrhp_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  byte_data,
   output logic        byte_ready,
   output logic        ev_push,
   output logic        ev_two,
   output event_type   ev0,
   output event_type   ev1,
   input  logic        q_room2
);

   localparam int OW = OFFSET_WIDTH;

   parse_phase_type pp_ff, pp_in;
   line_phase_type  lp_ff, lp_in;
   logic [OW-1:0] off_ff, off_in, tb_ff, tb_in, nb_ff, nb_in, nf_ff, nf_in;
   logic [OW-1:0] vb_ff, vb_in, vl_ff, vl_in;
   logic          cr_ff, cr_in;
   logic [3:0]    mi_ff, mi_in;
   logic          mok_ff, mok_in;
   logic [31:0]   dl_ff, dl_in, acc_ff, acc_in, bc_ff, bc_in;

   logic          fire;
   logic [OW-1:0] endo, offp1;
   logic [31:0]   bc_inc;
   event_type     e0, e1;
   logic          n0, n1;

   assign byte_ready = q_room2;
   assign fire       = byte_valid && byte_ready;
   assign offp1      = off_ff + 1'b1;
   assign endo       = off_ff - {{(OW-1){1'b0}}, cr_ff};
   assign bc_inc     = bc_ff + 32'd1;

   function automatic logic [31:0] w32(input logic [OW-1:0] v);
      logic [OW+31:0] t;
      t = {{32{1'b0}}, v};
      return t[31:0];
   endfunction

   // Header byte processing, applied up to twice (held CR, then current byte).
   function automatic void hdr(
      input logic [7:0] c, input logic [OW-1:0] o,
      inout line_phase_type lp, inout logic [OW-1:0] nb, inout logic [OW-1:0] nf,
      inout logic [OW-1:0] vb, inout logic [OW-1:0] vl, inout logic [3:0] mi,
      inout logic mok, inout logic [31:0] acc);
      logic b, dig;
      logic [7:0] lc;
      logic [35:0] v;
      b   = (c == CH_SP) || (c == CH_TAB);
      dig = (c >= "0") && (c <= "9");
      lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      v   = {acc[31:0], 3'b000} + {3'b000, acc, 1'b0} + {28'd0, c - 8'h30};
      unique case (lp)
         LP_LEAD, LP_NAME: begin
            if (lp == LP_LEAD && b) begin
            end else begin
               if (lp == LP_LEAD) nb = o;
               if (c == CH_COLON || (b && lp == LP_NAME)) begin
                  nf = o;
                  if (mi != NAME_LEN) mok = 1'b0;
                  lp = (c == CH_COLON) ? LP_GAP : LP_SEEK;
               end else begin
                  lp = LP_NAME;
                  if (mok && mi < NAME_LEN && lc == name_char(mi)) mi = mi + 4'd1;
                  else mok = 1'b0;
               end
            end
         end
         LP_SEEK: if (c == CH_COLON) lp = LP_GAP;
         default: begin
            if (!(lp == LP_GAP && b)) begin
               if (lp == LP_GAP) begin
                  vb = o;
                  lp = LP_VALUE;
               end
               if (!b) vl = o;
               if (mok && mi == NAME_LEN) begin
                  if (dig) acc = (v > {4'd0, LEN_SAT}) ? LEN_SAT : v[31:0];
                  else mi = NUM_STOP;
               end
            end
         end
      endcase
   endfunction

   always_comb begin
      line_phase_type lpt;
      logic [OW-1:0] nbt, nft, vbt, vlt;
      logic [3:0] mit;
      logic mokt;
      logic [31:0] acct;
      pp_in = pp_ff; lp_in = lp_ff; off_in = off_ff; tb_in = tb_ff;
      nb_in = nb_ff; nf_in = nf_ff; vb_in = vb_ff; vl_in = vl_ff;
      cr_in = cr_ff; mi_in = mi_ff; mok_in = mok_ff; dl_in = dl_ff;
      acc_in = acc_ff; bc_in = bc_ff;
      e0 = '0; e1 = '0; n0 = 1'b0; n1 = 1'b0;
      lpt = lp_ff; nbt = nb_ff; nft = nf_ff; vbt = vb_ff; vlt = vl_ff;
      mit = mi_ff; mokt = mok_ff; acct = acc_ff;
      if (fire && pp_ff != PH_DONE) begin
         cr_in  = (byte_data == CH_CR);
         off_in = offp1;
         unique case (pp_ff)
            PH_METHOD, PH_TARGET: if (byte_data == CH_SP) begin
               n0 = 1'b1;
               e0.kind = (pp_ff == PH_METHOD) ? TK_METHOD : TK_TARGET;
               e0.offset = w32(tb_ff); e0.length = w32(off_ff - tb_ff);
               tb_in = offp1;
               pp_in = (pp_ff == PH_METHOD) ? PH_TARGET : PH_VERSION;
            end
            PH_VERSION: if (byte_data == CH_LF) begin
               n0 = 1'b1;
               e0.kind = TK_VERSION;
               e0.offset = w32(tb_ff); e0.length = w32(endo - tb_ff);
               tb_in = offp1; pp_in = PH_HEADERS;
               lp_in = LP_LEAD; mi_in = 4'd0; mok_in = 1'b1; acc_in = '0;
            end
            PH_HEADERS: begin
               if (byte_data == CH_LF) begin
                  if (endo == tb_ff) begin
                     n0 = 1'b1;
                     e0.kind = TK_HEND; e0.length = w32(tb_ff);
                     if (dl_ff == NO_LENGTH || dl_ff == 32'd0) begin
                        n1 = 1'b1; e1.kind = TK_DONE; pp_in = PH_DONE;
                     end else begin
                        pp_in = PH_BODY; bc_in = '0; tb_in = offp1;
                     end
                  end else begin
                     if (lp_ff == LP_LEAD) begin
                        nbt = endo; nft = endo; mokt = 1'b0;
                     end else if (lp_ff == LP_NAME) begin
                        nft = endo;
                        if (mi_ff != NAME_LEN) mokt = 1'b0;
                     end
                     n0 = 1'b1; n1 = 1'b1;
                     e0.kind = TK_NAME; e0.offset = w32(nbt);
                     e0.length = w32(nft - nbt);
                     e1.kind = TK_VALUE;
                     if (lp_ff == LP_VALUE) begin
                        e1.offset = w32(vb_ff); e1.length = w32(vl_ff + 1'b1 - vb_ff);
                     end else begin
                        e1.offset = w32(endo);
                     end
                     if (mokt && mi_ff >= NAME_LEN && dl_ff == NO_LENGTH)
                        dl_in = acc_ff;
                     nb_in = nbt; nf_in = nft;
                     tb_in = offp1; lp_in = LP_LEAD; mi_in = 4'd0;
                     mok_in = 1'b1; acc_in = '0;
                  end
               end else begin
                  if (cr_ff)
                     hdr(CH_CR, off_ff - 1'b1, lpt, nbt, nft, vbt, vlt, mit, mokt, acct);
                  if (byte_data != CH_CR)
                     hdr(byte_data, off_ff, lpt, nbt, nft, vbt, vlt, mit, mokt, acct);
                  lp_in = lpt; nb_in = nbt; nf_in = nft; vb_in = vbt; vl_in = vlt;
                  mi_in = mit; mok_in = mokt; acc_in = acct;
               end
            end
            PH_BODY: begin
               bc_in = bc_inc;
               if (bc_inc >= dl_ff) begin
                  n0 = 1'b1; n1 = 1'b1;
                  e0.kind = TK_BODY; e0.offset = w32(tb_ff); e0.length = dl_ff;
                  e1.kind = TK_DONE; pp_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
      e0.body_len = dl_ff; e1.body_len = dl_ff;
      e0.last = !n1; e1.last = 1'b1;
   end

   assign ev_push = n0;
   assign ev_two  = n1;
   assign ev0 = e0;
   assign ev1 = e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff <= PH_METHOD; lp_ff <= LP_LEAD; off_ff <= '0; tb_ff <= '0;
         nb_ff <= '0; nf_ff <= '0; vb_ff <= '0; vl_ff <= '0; cr_ff <= 1'b0;
         mi_ff <= '0; mok_ff <= 1'b1; dl_ff <= NO_LENGTH; acc_ff <= '0; bc_ff <= '0;
      end else begin
         pp_ff <= pp_in; lp_ff <= lp_in; off_ff <= off_in; tb_ff <= tb_in;
         nb_ff <= nb_in; nf_ff <= nf_in; vb_ff <= vb_in; vl_ff <= vl_in;
         cr_ff <= cr_in; mi_ff <= mi_in; mok_ff <= mok_in; dl_ff <= dl_in;
         acc_ff <= acc_in; bc_ff <= bc_in;
      end
   end

endmodule

>>> rtl/core/hrhp_queue.sv
`timescale 1ns / 1ps
module hrhp_queue import hrhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  logic      push_two,
   input  event_type din0,
   input  event_type din1,
   output logic      room2,
   output logic      out_valid,
   output event_type dout,
   input  logic      out_ready
);

   localparam int DEPTH = 4;

   event_type   mem_ff [DEPTH];
   logic [1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;

   assign out_valid = (cnt_ff != 3'd0);
   assign dout      = mem_ff[rp_ff];
   assign pop       = out_valid && out_ready;
   assign room2     = (cnt_ff <= 3'd2);

   always_comb begin
      wp_in  = wp_ff + (push ? (push_two ? 2'd2 : 2'd1) : 2'd0);
      rp_in  = rp_ff + {1'b0, pop};
      cnt_in = cnt_ff + (push ? (push_two ? 3'd2 : 3'd1) : 3'd0) - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= din0;
      if (push && push_two) mem_ff[wp_ff + 2'd1] <= din1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

endmodule
